@@ hdl/mbrtu_pkg.sv @@
// Shared types, codes and the byte-wide CRC-16 step for the Modbus RTU slave.
// No dependencies; every other file of the block imports this package.
package mbrtu_pkg;

   // Request operation codes.
   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_EOF  = 2'd1;
   localparam logic [1:0] OP_LIVE = 2'd2;

   // Kinds of work queued between the front and the back.
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_EOF  = 2'd1;
   localparam logic [1:0] KIND_LIVE = 2'd2;

   // Frame index width that covers every supported frame store depth.
   localparam int IDX_W = 8;

   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;
   localparam logic [7:0]  FC_READ     = 8'h03;
   localparam logic [7:0]  FC_WRITE    = 8'h10;
   localparam logic [15:0] SAVE_MAGIC  = 16'hAAAA;
   localparam logic [15:0] MAX_WR_REGS = 16'd123;

   // Holding register addresses.
   localparam logic [15:0] REG_ADDR     = 16'd0;
   localparam logic [15:0] REG_BAUD     = 16'd1;
   localparam logic [15:0] REG_PULSE_HI = 16'd2;
   localparam logic [15:0] REG_PULSE_LO = 16'd3;
   localparam logic [15:0] REG_WHEEL_HI = 16'd4;
   localparam logic [15:0] REG_WHEEL_LO = 16'd5;
   localparam logic [15:0] REG_DIST_HI  = 16'd6;
   localparam logic [15:0] REG_DIST_LO  = 16'd7;
   localparam logic [15:0] REG_SAVE     = 16'd8;
   localparam logic [15:0] REG_HOMED    = 16'd9;
   localparam logic [15:0] REG_LAPS     = 16'd10;
   localparam logic [15:0] REG_PPR      = 16'd11;

   typedef struct packed {
      logic [1:0]        kind;
      logic [7:0]        data;
      logic [IDX_W-1:0]  idx;     // store index for a byte, frame length for an end of frame
      logic              crc_ok;
      logic signed [31:0] live_pulse_count;
      logic [31:0]       live_distance_bits;
      logic              live_homed;
      logic signed [15:0] live_laps;
   } item_type;

   // One received or transmitted byte folded into a reflected CRC-16.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

@@ hdl/modbus_rtu_slave_register_map.sv @@
// Modbus RTU slave (function codes 3 and 16) over a small holding-register map.
// This block takes received bytes, end-of-frame marks and live encoder updates on
// the req_ channel and sends response bytes on the rsp_ channel. Bytes are kept in
// a frame store of FRAME_DEPTH entries; a byte that fills the store restarts the
// frame at entry 0. The CRC-16 is folded in per byte as it arrives, so the back
// end handles a received byte or live update without leaving idle. At end of frame
// the back end fetches the seven header bytes from the store and checks length,
// address and CRC; a bad frame is dropped without any response. A read request then
// streams 5 + 2 x count bytes, one per cycle while the response side does not stall.
// A write request takes each register through two store reads and the update
// and then echoes the six header bytes plus CRC, so pulse_value on every response
// byte already reflects the writes. Register 8 written with 0xAAAA raises
// save_request on the final byte, and a write to register 2 or 3 raises pulse_reload.
// A two-entry queue between the front end and the back end lets requests keep
// arriving while a response transfer is held off. Parameter FRAME_DEPTH (16..256)
// sets the store depth, MAX_READ_REGS (1..125) the largest accepted read count.
module modbus_rtu_slave_register_map #(
   parameter int FRAME_DEPTH   = 64,
   parameter int MAX_READ_REGS = 29
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_operation,
   input  logic [7:0]          req_rx_byte,
   input  logic signed [31:0]  req_live_pulse_count,
   input  logic [31:0]         req_live_distance_bits,
   input  logic                req_live_homed,
   input  logic signed [15:0]  req_live_laps,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_tx_byte,
   output logic                rsp_tx_last,
   output logic                rsp_save_request,
   output logic                rsp_pulse_reload,
   output logic signed [31:0]  rsp_pulse_value
);
   import mbrtu_pkg::*;

   item_type push_item;
   item_type pop_item;
   logic     push;
   logic     pop;
   logic     full;
   logic     empty;

   // Front end: classifies each transfer and keeps the running frame length and CRC.
   mbrtu_front #(.FRAME_DEPTH(FRAME_DEPTH)) u_front (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_operation          (req_operation),
      .req_rx_byte            (req_rx_byte),
      .req_live_pulse_count   (req_live_pulse_count),
      .req_live_distance_bits (req_live_distance_bits),
      .req_live_homed         (req_live_homed),
      .req_live_laps          (req_live_laps),
      .q_full                 (full),
      .q_push                 (push),
      .q_item                 (push_item)
   );

   // Short queue so the front end keeps accepting while the back end is busy.
   mbrtu_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .full      (full),
      .empty     (empty)
   );

   // Back end: frame store, register map and response sequencer.
   mbrtu_back #(.FRAME_DEPTH(FRAME_DEPTH), .MAX_READ_REGS(MAX_READ_REGS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (empty),
      .q_item           (pop_item),
      .q_pop            (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tx_byte      (rsp_tx_byte),
      .rsp_tx_last      (rsp_tx_last),
      .rsp_save_request (rsp_save_request),
      .rsp_pulse_reload (rsp_pulse_reload),
      .rsp_pulse_value  (rsp_pulse_value)
   );

endmodule

@@ hdl/mbrtu_front.sv @@
// Front of the Modbus RTU slave: accepts requests, tracks frame length and CRC.
// Depends on mbrtu_pkg.
module mbrtu_front #(
   parameter int FRAME_DEPTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_operation,
   input  logic [7:0]           req_rx_byte,
   input  logic signed [31:0]   req_live_pulse_count,
   input  logic [31:0]          req_live_distance_bits,
   input  logic                 req_live_homed,
   input  logic signed [15:0]   req_live_laps,
   input  logic                 q_full,
   output logic                 q_push,
   output mbrtu_pkg::item_type  q_item
);
   import mbrtu_pkg::*;

   localparam int LW = $clog2(FRAME_DEPTH);

   logic [LW-1:0] len_ff, len_in;
   logic [15:0]   crc_ff, crc_in;
   logic          accept;
   logic          wrap;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign wrap      = (len_ff == LW'(FRAME_DEPTH - 1));

   always_comb begin
      len_in = len_ff;
      crc_in = crc_ff;
      q_push = 1'b0;
      q_item.kind               = KIND_BYTE;
      q_item.data               = req_rx_byte;
      q_item.idx                = IDX_W'(len_ff);
      q_item.crc_ok             = (crc_ff == 16'h0000);
      q_item.live_pulse_count   = req_live_pulse_count;
      q_item.live_distance_bits = req_live_distance_bits;
      q_item.live_homed         = req_live_homed;
      q_item.live_laps          = req_live_laps;
      if (accept) begin
         case (req_operation)
            OP_BYTE: begin
               q_push = 1'b1;
               // A byte that fills the store restarts collection and the CRC.
               len_in = wrap ? '0 : len_ff + LW'(1);
               crc_in = wrap ? CRC_INIT : crc_byte(crc_ff, req_rx_byte);
            end
            OP_EOF: begin
               q_push      = 1'b1;
               q_item.kind = KIND_EOF;
               len_in      = '0;
               crc_in      = CRC_INIT;
            end
            OP_LIVE: begin
               q_push      = 1'b1;
               q_item.kind = KIND_LIVE;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         crc_ff <= CRC_INIT;
      end else begin
         len_ff <= len_in;
         crc_ff <= crc_in;
      end
   end

endmodule

@@ hdl/mbrtu_fifo.sv @@
// Two-entry queue of work items between the front and the back.
// Depends on mbrtu_pkg.
module mbrtu_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mbrtu_pkg::item_type  push_item,
   input  logic                 pop,
   output mbrtu_pkg::item_type  pop_item,
   output logic                 full,
   output logic                 empty
);
   import mbrtu_pkg::*;

   item_type   ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_item = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

@@ hdl/mbrtu_back.sv @@
// Back of the Modbus RTU slave: frame store, register map, request sequencer
// and response output register. Depends on mbrtu_pkg.
module mbrtu_back #(
   parameter int FRAME_DEPTH   = 64,
   parameter int MAX_READ_REGS = 29
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  mbrtu_pkg::item_type  q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_tx_byte,
   output logic                 rsp_tx_last,
   output logic                 rsp_save_request,
   output logic                 rsp_pulse_reload,
   output logic signed [31:0]   rsp_pulse_value
);
   import mbrtu_pkg::*;

   localparam int LW = $clog2(FRAME_DEPTH);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_HDR   = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_WHI   = 3'd3;
   localparam logic [2:0] ST_WLO   = 3'd4;
   localparam logic [2:0] ST_WAPP  = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [7:0]    mem [FRAME_DEPTH];
   logic [7:0]    mem_q_ff;
   logic [LW-1:0] rd_addr;

   logic [2:0]    state_ff;
   logic [2:0]    hj_ff;
   logic [7:0]    hdr_ff [7];
   logic [LW-1:0] len_ff;
   logic          crc_ok_ff;
   logic [15:0]   reg_ff;
   logic [6:0]    cnt_ff;
   logic [LW-1:0] ptr_ff;
   logic [7:0]    whi_ff;
   logic [7:0]    k_ff;
   logic [7:0]    total_ff;
   logic          is_read_ff;
   logic          save_ff;
   logic          reload_ff;
   logic [15:0]   tx_crc_ff;

   logic [15:0]   device_address_ff;
   logic [15:0]   baud_code_ff;
   logic [31:0]   wheel_ff;
   logic [15:0]   ppr_ff;
   logic [31:0]   pulse_ff;
   logic [31:0]   dist_ff;
   logic          homed_ff;
   logic [15:0]   laps_ff;

   logic          rsp_valid_ff;
   logic [7:0]    rsp_byte_ff;
   logic          rsp_last_ff;
   logic          rsp_save_ff;
   logic          rsp_reload_ff;
   logic [31:0]   rsp_pulse_ff;

   logic [15:0]   start_w;
   logic [15:0]   count_w;
   logic          read_ok;
   logic          write_ok;
   logic          emit_go;
   logic          emit_last;
   logic [7:0]    emit_byte;
   logic [15:0]   reg_val;
   logic [15:0]   wr_val;

   function automatic logic [15:0] read_reg(
      input logic [15:0] r, input logic [15:0] dev, input logic [15:0] baud,
      input logic [31:0] pulse, input logic [31:0] wheel, input logic [31:0] distance,
      input logic homed, input logic [15:0] laps, input logic [15:0] ppr);
      logic [15:0] v;
      case (r)
         REG_ADDR:     v = dev;
         REG_BAUD:     v = baud;
         REG_PULSE_HI: v = pulse[31:16];
         REG_PULSE_LO: v = pulse[15:0];
         REG_WHEEL_HI: v = wheel[31:16];
         REG_WHEEL_LO: v = wheel[15:0];
         REG_DIST_HI:  v = distance[31:16];
         REG_DIST_LO:  v = distance[15:0];
         REG_HOMED:    v = {15'd0, homed};
         REG_LAPS:     v = laps;
         REG_PPR:      v = ppr;
         default:      v = 16'd0;
      endcase
      return v;
   endfunction

   assign q_pop   = (state_ff == ST_IDLE) && !q_empty;
   assign start_w = {hdr_ff[2], hdr_ff[3]};
   assign count_w = {hdr_ff[4], hdr_ff[5]};
   assign wr_val  = {whi_ff, mem_q_ff};

   assign read_ok = (hdr_ff[1] == FC_READ) && (len_ff == LW'(8)) &&
                    (count_w != 16'd0) && (count_w <= 16'(MAX_READ_REGS));
   assign write_ok = (hdr_ff[1] == FC_WRITE) && (count_w != 16'd0) &&
                     (count_w <= MAX_WR_REGS) &&
                     ({8'd0, hdr_ff[6]} == {count_w[14:0], 1'b0}) &&
                     (17'(len_ff) == 17'd9 + {count_w, 1'b0});

   always_comb begin
      case (state_ff)
         ST_HDR:  rd_addr = LW'(hj_ff);
         ST_WHI:  rd_addr = ptr_ff;
         ST_WLO:  rd_addr = ptr_ff + LW'(1);
         default: rd_addr = '0;
      endcase
   end

   assign reg_val = read_reg(reg_ff, device_address_ff, baud_code_ff, pulse_ff,
                             wheel_ff, dist_ff, homed_ff, laps_ff, ppr_ff);

   always_comb begin
      if (k_ff < total_ff) begin
         if (!is_read_ff) begin
            emit_byte = hdr_ff[k_ff[2:0]];
         end else if (k_ff == 8'd0) begin
            emit_byte = device_address_ff[7:0];
         end else if (k_ff == 8'd1) begin
            emit_byte = FC_READ;
         end else if (k_ff == 8'd2) begin
            emit_byte = total_ff - 8'd3;
         end else begin
            emit_byte = k_ff[0] ? reg_val[15:8] : reg_val[7:0];
         end
      end else if (k_ff == total_ff) begin
         emit_byte = tx_crc_ff[7:0];
      end else begin
         emit_byte = tx_crc_ff[15:8];
      end
   end

   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign emit_last = (k_ff == total_ff + 8'd1);

   always_ff @(posedge clock) begin
      if (q_pop && (q_item.kind == KIND_BYTE)) begin
         mem[q_item.idx[LW-1:0]] <= q_item.data;
      end
      mem_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         device_address_ff <= 16'd1;
         baud_code_ff      <= 16'd0;
         wheel_ff          <= 32'h4348_0000;
         ppr_ff            <= 16'd20;
         pulse_ff          <= 32'd0;
         dist_ff           <= 32'd0;
         homed_ff          <= 1'b0;
         laps_ff           <= 16'd0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         // The output register loads a new byte or empties once its transfer is taken.
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  case (q_item.kind)
                     KIND_LIVE: begin
                        pulse_ff <= q_item.live_pulse_count;
                        dist_ff  <= q_item.live_distance_bits;
                        homed_ff <= q_item.live_homed;
                        laps_ff  <= q_item.live_laps;
                     end
                     KIND_EOF: begin
                        len_ff    <= q_item.idx[LW-1:0];
                        crc_ok_ff <= q_item.crc_ok;
                        hj_ff     <= 3'd0;
                        state_ff  <= ST_HDR;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_HDR: begin
               if (hj_ff != 3'd0) begin
                  hdr_ff[hj_ff - 3'd1] <= mem_q_ff;
               end
               hj_ff <= hj_ff + 3'd1;
               if (hj_ff == 3'd7) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               reg_ff    <= start_w;
               k_ff      <= 8'd0;
               tx_crc_ff <= CRC_INIT;
               save_ff   <= 1'b0;
               reload_ff <= 1'b0;
               ptr_ff    <= LW'(7);
               cnt_ff    <= count_w[6:0];
               if ((len_ff < LW'(4)) || !crc_ok_ff ||
                   ({8'd0, hdr_ff[0]} != device_address_ff)) begin
                  state_ff <= ST_IDLE;
               end else if (read_ok) begin
                  is_read_ff <= 1'b1;
                  total_ff   <= 8'd3 + {count_w[6:0], 1'b0};
                  state_ff   <= ST_EMIT;
               end else if (write_ok) begin
                  is_read_ff <= 1'b0;
                  total_ff   <= 8'd6;
                  state_ff   <= ST_WHI;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_WHI: begin
               state_ff <= ST_WLO;
            end
            ST_WLO: begin
               whi_ff   <= mem_q_ff;
               state_ff <= ST_WAPP;
            end
            ST_WAPP: begin
               case (reg_ff)
                  REG_ADDR: device_address_ff <= wr_val;
                  REG_BAUD: baud_code_ff <= wr_val;
                  REG_PULSE_HI: begin
                     pulse_ff[31:16] <= wr_val;
                     reload_ff       <= 1'b1;
                  end
                  REG_PULSE_LO: begin
                     pulse_ff[15:0] <= wr_val;
                     reload_ff      <= 1'b1;
                  end
                  REG_WHEEL_HI: wheel_ff[31:16] <= wr_val;
                  REG_WHEEL_LO: wheel_ff[15:0] <= wr_val;
                  REG_SAVE: begin
                     if (wr_val == SAVE_MAGIC) begin
                        save_ff <= 1'b1;
                     end
                  end
                  REG_PPR: ppr_ff <= wr_val;
                  default: begin
                  end
               endcase
               reg_ff <= reg_ff + 16'd1;
               ptr_ff <= ptr_ff + LW'(2);
               cnt_ff <= cnt_ff - 7'd1;
               state_ff <= (cnt_ff == 7'd1) ? ST_EMIT : ST_WHI;
            end
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_byte_ff   <= emit_byte;
                  rsp_last_ff   <= emit_last;
                  rsp_save_ff   <= emit_last && save_ff;
                  rsp_reload_ff <= emit_last && reload_ff;
                  rsp_pulse_ff  <= pulse_ff;
                  k_ff          <= k_ff + 8'd1;
                  if (k_ff < total_ff) begin
                     tx_crc_ff <= crc_byte(tx_crc_ff, emit_byte);
                  end
                  // A register value is done once its low byte has gone out.
                  if (is_read_ff && (k_ff >= 8'd4) && !k_ff[0]) begin
                     reg_ff <= reg_ff + 16'd1;
                  end
                  if (emit_last) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tx_byte      = rsp_byte_ff;
   assign rsp_tx_last      = rsp_last_ff;
   assign rsp_save_request = rsp_save_ff;
   assign rsp_pulse_reload = rsp_reload_ff;
   assign rsp_pulse_value  = rsp_pulse_ff;

`ifndef ASSERT_OFF
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (k_ff <= total_ff + 8'd1))
      else $error("response byte counter ran past the response length");
   a_wapp_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAPP) |-> (cnt_ff != 7'd0))
      else $error("write sequencer applied a register with no count left");
   a_hdr_flow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HDR) |=> ((state_ff == ST_HDR) || (state_ff == ST_CHECK)))
      else $error("header fetch left for an unexpected state");
   a_last_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_save_ff || rsp_reload_ff)) |-> rsp_last_ff)
      else $error("save or reload strobe away from the final byte");
`endif

endmodule
